// ----- design/brs_pkg.sv -----
// Shared types, field widths, status codes and helpers for the block reception scoreboard.
// Used by brs_front, brs_back and block_reception_scoreboard; depends on nothing else.
package brs_pkg;

  localparam int IDX_W          = 10;
  localparam int TOT_W          = 11;
  localparam int VER_W          = 31;
  localparam int CRE_W          = 32;
  localparam int ST_W           = 2;
  localparam int WORD_W         = 32;
  localparam int BIT_W          = 5;
  localparam int MAP_CAP        = 1024;
  localparam int MAX_BLOCKS_DEF = 1024;

  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);
  localparam logic [QPW-1:0] QLAST = QPW'(QDEPTH - 1);
  localparam logic [QCW-1:0] QFULL = QCW'(QDEPTH);

  localparam logic [ST_W-1:0] ST_ACCEPT = 2'd0;
  localparam logic [ST_W-1:0] ST_DUP    = 2'd1;
  localparam logic [ST_W-1:0] ST_OLD    = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE  = 2'd3;

  // One queued item with the checks that do not depend on tracking state.
  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic [TOT_W-1:0]        total;
    logic [VER_W-1:0]        version;
    logic signed [CRE_W-1:0] creator;
    logic                    bad_restart;
    logic                    idx_ge_max;
  } brs_item_t;

  // Returns {found, position} of the lowest clear bit of a bitmap word.
  function automatic logic [BIT_W:0] lowest_zero(input logic [WORD_W-1:0] w);
    logic [BIT_W:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        r = {1'b1, BIT_W'(i)};
      end
    end
    return r;
  endfunction

endpackage

// ----- design/block_reception_scoreboard.sv -----
// Top level of the block reception scoreboard: front queue plus back sequencer.
// Depends on brs_pkg, brs_front and brs_back.
//
// Usage: each input item is one received block (index, total count, version, creator).
// Both channels use valid/stall; an item moves on a rising edge with valid high and stall
// low. Every input item produces exactly one result item, in order: a status, a restart
// flag, the lowest missing block, the received count and a completion flag.
// The front queue holds two items, so in_stall rises only when both entries are taken.
// The back end handles one item at a time. Its first-missing scan reads the 32-bit bitmap
// words one per cycle through the single read port of the bitmap memory and stops at the
// first word with a gap; a rejection with no transfer tracked skips the scan.
// Reset (synchronous, active low) empties the queue, drops any tracked or committed
// version and clears the per-word valid flags, so the whole bitmap reads as empty at
// once; no clearing pass is needed and items are taken in the cycle after reset.
// When the receiver stalls, the result waits in the output register, the back end
// holds its finished result, and the queue keeps taking items until it is full.
module block_reception_scoreboard #(
  parameter int MAX_BLOCKS = brs_pkg::MAX_BLOCKS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [brs_pkg::IDX_W-1:0]         in_block_index,
  input  logic [brs_pkg::TOT_W-1:0]         in_total_blocks,
  input  logic [brs_pkg::VER_W-1:0]         in_file_version,
  input  logic signed [brs_pkg::CRE_W-1:0]  in_creator_id,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [brs_pkg::ST_W-1:0]          out_status,
  output logic                              out_restarted,
  output logic [brs_pkg::IDX_W-1:0]         out_next_missing,
  output logic [brs_pkg::TOT_W-1:0]         out_received_count,
  output logic                              out_complete
);

  // Queue handoff between the front and back halves.
  logic               q_valid;
  logic               q_pop;
  brs_pkg::brs_item_t q_item;

  // The front takes items and does the range checks that need no tracking state.
  brs_front #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_block_index (in_block_index),
    .in_total_blocks(in_total_blocks),
    .in_file_version(in_file_version),
    .in_creator_id  (in_creator_id),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  // The back compares versions, marks the bitmap, scans for the first gap and
  // holds the result until the receiver takes it.
  brs_back #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_restarted     (out_restarted),
    .out_next_missing  (out_next_missing),
    .out_received_count(out_received_count),
    .out_complete      (out_complete)
  );

endmodule

// ----- design/brs_front.sv -----
// Front end of the block reception scoreboard: accepts items, checks ranges, queues them.
// Depends on brs_pkg.
module brs_front #(
  parameter int MAX_BLOCKS = brs_pkg::MAX_BLOCKS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [brs_pkg::IDX_W-1:0]         in_block_index,
  input  logic [brs_pkg::TOT_W-1:0]         in_total_blocks,
  input  logic [brs_pkg::VER_W-1:0]         in_file_version,
  input  logic signed [brs_pkg::CRE_W-1:0]  in_creator_id,
  output logic                              q_valid,
  output brs_pkg::brs_item_t                q_item,
  input  logic                              q_pop
);

  localparam logic [31:0] MAX_U = 32'(MAX_BLOCKS);

  brs_pkg::brs_item_t               q_mem_r [brs_pkg::QDEPTH];
  logic [brs_pkg::QPW-1:0]          wr_ptr_r, wr_ptr_nxt;
  logic [brs_pkg::QPW-1:0]          rd_ptr_r, rd_ptr_nxt;
  logic [brs_pkg::QCW-1:0]          cnt_r, cnt_nxt;
  brs_pkg::brs_item_t               new_item;
  logic                             push;
  logic                             pop;

  assign in_stall = (cnt_r == brs_pkg::QFULL);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = q_mem_r[rd_ptr_r];

  always_comb begin
    new_item.idx         = in_block_index;
    new_item.total       = in_total_blocks;
    new_item.version     = in_file_version;
    new_item.creator     = in_creator_id;
    new_item.bad_restart = (in_total_blocks == '0) || (32'(in_total_blocks) > MAX_U) ||
                           ({1'b0, in_block_index} >= in_total_blocks);
    new_item.idx_ge_max  = 32'(in_block_index) >= MAX_U;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == brs_pkg::QLAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == brs_pkg::QLAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

// ----- design/brs_back.sv -----
// Back end of the block reception scoreboard: version checks, bitmap memory, scan, result.
// Depends on brs_pkg; takes queued items from brs_front.
module brs_back #(
  parameter int MAX_BLOCKS = brs_pkg::MAX_BLOCKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  brs_pkg::brs_item_t          q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [brs_pkg::ST_W-1:0]    out_status,
  output logic                        out_restarted,
  output logic [brs_pkg::IDX_W-1:0]   out_next_missing,
  output logic [brs_pkg::TOT_W-1:0]   out_received_count,
  output logic                        out_complete
);

  localparam int MAP_BITS = (MAX_BLOCKS < brs_pkg::MAP_CAP) ? MAX_BLOCKS : brs_pkg::MAP_CAP;
  localparam int WORDS    = (MAP_BITS + brs_pkg::WORD_W - 1) / brs_pkg::WORD_W;
  localparam int WA       = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [brs_pkg::TOT_W-1:0] MAP_U  = brs_pkg::TOT_W'(MAP_BITS);
  localparam logic [15:0]               MAP_16 = 16'(MAP_BITS);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CLASS = 6'b000010,
    S_READ  = 6'b000100,
    S_MARK  = 6'b001000,
    S_SCAN  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t                            state_r, state_nxt;
  brs_pkg::brs_item_t                it_r, it_nxt;
  logic                              active_r, active_nxt;
  logic [brs_pkg::VER_W-1:0]         tver_r, tver_nxt;
  logic signed [brs_pkg::CRE_W-1:0]  tcre_r, tcre_nxt;
  logic [brs_pkg::TOT_W-1:0]         ttot_r, ttot_nxt;
  logic [brs_pkg::TOT_W-1:0]         rcv_r, rcv_nxt;
  logic                              cval_r, cval_nxt;
  logic [brs_pkg::VER_W-1:0]         cver_r, cver_nxt;
  logic signed [brs_pkg::CRE_W-1:0]  ccre_r, ccre_nxt;
  logic [WA-1:0]                     iss_r, iss_nxt;
  logic [WA-1:0]                     chk_addr_r, chk_addr_nxt;
  logic                              chk_vld_r, chk_vld_nxt;
  logic                              mark_r, mark_nxt;
  logic [brs_pkg::ST_W-1:0]          res_status_r, res_status_nxt;
  logic                              res_restart_r, res_restart_nxt;
  logic [brs_pkg::IDX_W-1:0]         res_next_r, res_next_nxt;
  logic [brs_pkg::TOT_W-1:0]         res_count_r, res_count_nxt;
  logic                              res_complete_r, res_complete_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [brs_pkg::ST_W-1:0]          out_status_r;
  logic                              out_restarted_r;
  logic [brs_pkg::IDX_W-1:0]         out_next_r;
  logic [brs_pkg::TOT_W-1:0]         out_count_r;
  logic                              out_complete_r;

  logic [brs_pkg::WORD_W-1:0]        mem [WORDS];
  logic [WORDS-1:0]                  wvalid_r;
  logic [brs_pkg::WORD_W-1:0]        rd_data_r;
  logic                              rd_wvld_r;
  logic [WA-1:0]                     rd_addr;
  logic                              mem_we;
  logic                              wclr;
  logic                              out_load;

  logic                              newer_c, newer_t, same_t, idx_ge_ttot;
  logic                              rej;
  logic [brs_pkg::ST_W-1:0]          rej_code;
  logic [15:0]                       idx16;
  logic [WA-1:0]                     word_idx;
  logic [brs_pkg::WORD_W-1:0]        cur_word;
  logic [brs_pkg::WORD_W-1:0]        marked_word;
  logic                              cur_bit;
  logic [brs_pkg::TOT_W-1:0]         lim_eff, lim_m1;
  logic                              over;
  logic [WA-1:0]                     last_word;
  logic [brs_pkg::BIT_W-1:0]         last_bit;
  logic [brs_pkg::WORD_W-1:0]        fill;
  logic [brs_pkg::WORD_W-1:0]        chk_word;
  logic [brs_pkg::BIT_W:0]           zres;
  logic [15:0]                       found16;
  logic                              missing;

  // Version ordering: higher version wins, equal versions fall back to the signed creator.
  assign newer_c = (it_r.version == cver_r) ? (it_r.creator > ccre_r) : (it_r.version > cver_r);
  assign newer_t = (it_r.version == tver_r) ? (it_r.creator > tcre_r) : (it_r.version > tver_r);
  assign same_t  = (it_r.version == tver_r) && (it_r.creator == tcre_r);
  assign idx_ge_ttot = ({1'b0, it_r.idx} >= ttot_r);

  assign idx16       = 16'(it_r.idx);
  assign word_idx    = idx16[WA+4:5];
  assign cur_word    = rd_wvld_r ? rd_data_r : '0;
  assign cur_bit     = cur_word[it_r.idx[brs_pkg::BIT_W-1:0]];
  assign marked_word = cur_word | (32'd1 << it_r.idx[brs_pkg::BIT_W-1:0]);

  // Scan bounds come from the tracked total, clipped to the stored bitmap.
  assign over      = (ttot_r > MAP_U);
  assign lim_eff   = over ? MAP_U : ttot_r;
  assign lim_m1    = lim_eff - 1'b1;
  assign last_word = WA'(lim_m1 >> brs_pkg::BIT_W);
  assign last_bit  = lim_m1[brs_pkg::BIT_W-1:0];
  assign fill      = ~(32'hFFFF_FFFF >> (5'd31 - last_bit));
  assign chk_word  = cur_word | ((chk_addr_r == last_word) ? fill : '0);
  assign zres      = brs_pkg::lowest_zero(chk_word);
  assign found16   = 16'({chk_addr_r, zres[brs_pkg::BIT_W-1:0]});
  assign missing   = zres[brs_pkg::BIT_W] || over;

  always_comb begin
    state_nxt        = state_r;
    it_nxt           = it_r;
    active_nxt       = active_r;
    tver_nxt         = tver_r;
    tcre_nxt         = tcre_r;
    ttot_nxt         = ttot_r;
    rcv_nxt          = rcv_r;
    cval_nxt         = cval_r;
    cver_nxt         = cver_r;
    ccre_nxt         = ccre_r;
    mark_nxt         = mark_r;
    res_status_nxt   = res_status_r;
    res_restart_nxt  = res_restart_r;
    res_next_nxt     = res_next_r;
    res_count_nxt    = res_count_r;
    res_complete_nxt = res_complete_r;
    iss_nxt          = '0;
    chk_vld_nxt      = 1'b0;
    chk_addr_nxt     = iss_r;
    q_pop            = 1'b0;
    mem_we           = 1'b0;
    wclr             = 1'b0;
    rd_addr          = iss_r;
    out_load         = 1'b0;
    rej              = 1'b0;
    rej_code         = brs_pkg::ST_OLD;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          it_nxt    = q_item;
          state_nxt = S_CLASS;
        end
      end
      S_CLASS: begin
        res_restart_nxt  = 1'b0;
        res_complete_nxt = 1'b0;
        mark_nxt         = 1'b0;
        if (cval_r && !newer_c) begin
          rej = 1'b1;
        end else if (!active_r || newer_t) begin
          if (it_r.bad_restart) begin
            rej      = 1'b1;
            rej_code = brs_pkg::ST_RANGE;
          end else begin
            wclr            = 1'b1;
            active_nxt      = 1'b1;
            tver_nxt        = it_r.version;
            tcre_nxt        = it_r.creator;
            ttot_nxt        = it_r.total;
            rcv_nxt         = '0;
            res_restart_nxt = 1'b1;
            state_nxt       = S_READ;
          end
        end else if (same_t) begin
          if (idx_ge_ttot || it_r.idx_ge_max) begin
            rej      = 1'b1;
            rej_code = brs_pkg::ST_RANGE;
          end else begin
            state_nxt = S_READ;
          end
        end else begin
          rej = 1'b1;
        end
        if (rej) begin
          res_status_nxt = rej_code;
          if (active_r) begin
            state_nxt = S_SCAN;
          end else begin
            res_next_nxt  = '0;
            res_count_nxt = '0;
            state_nxt     = S_EMIT;
          end
        end
      end
      S_READ: begin
        rd_addr   = word_idx;
        state_nxt = S_MARK;
      end
      S_MARK: begin
        state_nxt = S_SCAN;
        if (cur_bit) begin
          res_status_nxt = brs_pkg::ST_DUP;
        end else begin
          mem_we         = 1'b1;
          rcv_nxt        = rcv_r + 1'b1;
          mark_nxt       = 1'b1;
          res_status_nxt = brs_pkg::ST_ACCEPT;
        end
      end
      S_SCAN: begin
        rd_addr      = iss_r;
        chk_vld_nxt  = 1'b1;
        chk_addr_nxt = iss_r;
        iss_nxt      = (iss_r == last_word) ? iss_r : iss_r + 1'b1;
        if (chk_vld_r && (zres[brs_pkg::BIT_W] || (chk_addr_r == last_word))) begin
          res_count_nxt = rcv_r;
          state_nxt     = S_EMIT;
          if (mark_r && !missing) begin
            cval_nxt         = 1'b1;
            cver_nxt         = tver_r;
            ccre_nxt         = tcre_r;
            active_nxt       = 1'b0;
            res_complete_nxt = 1'b1;
            res_next_nxt     = '0;
          end else if (!missing) begin
            res_next_nxt = '0;
          end else if (zres[brs_pkg::BIT_W]) begin
            res_next_nxt = found16[brs_pkg::IDX_W-1:0];
          end else begin
            res_next_nxt = MAP_16[brs_pkg::IDX_W-1:0];
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 1'b0;
      tver_r      <= '0;
      tcre_r      <= '0;
      ttot_r      <= '0;
      rcv_r       <= '0;
      cval_r      <= 1'b0;
      cver_r      <= '0;
      ccre_r      <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      wvalid_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      tver_r      <= tver_nxt;
      tcre_r      <= tcre_nxt;
      ttot_r      <= ttot_nxt;
      rcv_r       <= rcv_nxt;
      cval_r      <= cval_nxt;
      cver_r      <= cver_nxt;
      ccre_r      <= ccre_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (wclr) begin
        wvalid_r <= '0;
      end else if (mem_we) begin
        wvalid_r[word_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    it_r           <= it_nxt;
    iss_r          <= iss_nxt;
    chk_addr_r     <= chk_addr_nxt;
    mark_r         <= mark_nxt;
    res_status_r   <= res_status_nxt;
    res_restart_r  <= res_restart_nxt;
    res_next_r     <= res_next_nxt;
    res_count_r    <= res_count_nxt;
    res_complete_r <= res_complete_nxt;
    if (out_load) begin
      out_status_r    <= res_status_r;
      out_restarted_r <= res_restart_r;
      out_next_r      <= res_next_r;
      out_count_r     <= res_count_r;
      out_complete_r  <= res_complete_r;
    end
  end

  // Bitmap word memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[word_idx] <= marked_word;
    end
    rd_data_r <= mem[rd_addr];
    rd_wvld_r <= wvalid_r[rd_addr];
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_restarted      = out_restarted_r;
  assign out_next_missing   = out_next_r;
  assign out_received_count = out_count_r;
  assign out_complete       = out_complete_r;

`ifndef SYNTHESIS
  a_count_in_total: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (rcv_r <= ttot_r))
    else $error("received count exceeds tracked total");

  a_complete_commits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && res_complete_r) |-> (!active_r && cval_r))
    else $error("completion without commit");

  a_complete_is_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_complete_r) |-> (out_status_r == brs_pkg::ST_ACCEPT &&
                                         out_count_r != '0))
    else $error("completion reported on a rejected item");

  a_dup_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == brs_pkg::ST_DUP) |-> !out_restarted_r)
    else $error("duplicate reported on a restarted transfer");

  a_mark_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> (rcv_r == $past(rcv_r) + 1'b1))
    else $error("mark did not advance the received count");
`endif

endmodule

// ----- tb/tb_block_reception_scoreboard.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for block_reception_scoreboard: directed and random block traffic.
// Depends on brs_pkg and the block_reception_scoreboard RTL only.
module tb_block_reception_scoreboard;

  localparam int MAP_BLOCKS  = brs_pkg::MAX_BLOCKS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  // One expected or observed result item, laid out like the output ports.
  typedef struct packed {
    logic [brs_pkg::ST_W-1:0]  status;
    logic                      restarted;
    logic [brs_pkg::IDX_W-1:0] first_gap;
    logic [brs_pkg::TOT_W-1:0] received_count;
    logic                      complete;
  } reception_t;

  logic                             clk;
  logic                             rst_n              = 1'b0;
  logic                             in_valid           = 1'b0;
  logic                             in_stall;
  logic [brs_pkg::IDX_W-1:0]        in_block_index     = '0;
  logic [brs_pkg::TOT_W-1:0]        in_total_blocks    = '0;
  logic [brs_pkg::VER_W-1:0]        in_file_version    = '0;
  logic signed [brs_pkg::CRE_W-1:0] in_creator_id      = '0;
  logic                             out_valid;
  logic                             out_stall          = 1'b0;
  logic [brs_pkg::ST_W-1:0]         out_status;
  logic                             out_restarted;
  logic [brs_pkg::IDX_W-1:0]        out_next_missing;
  logic [brs_pkg::TOT_W-1:0]        out_received_count;
  logic                             out_complete;

  // Predictor state: a private copy of the reception bitmap, the tracked transfer and the
  // last committed version. It is advanced once per accepted item, in acceptance order.
  logic [MAP_BLOCKS-1:0]            rx_map;
  logic                             xfer_active;
  logic [brs_pkg::VER_W-1:0]        trk_ver;
  logic signed [brs_pkg::CRE_W-1:0] trk_cre;
  logic [brs_pkg::TOT_W-1:0]        trk_total;
  logic [brs_pkg::TOT_W-1:0]        rx_count;
  logic                             commit_ok;
  logic [brs_pkg::VER_W-1:0]        commit_ver;
  logic signed [brs_pkg::CRE_W-1:0] commit_cre;

  // Results the block still owes us, oldest first.
  reception_t due_receptions[$];

  int mismatch_count = 0;
  int items_sent     = 0;
  int cycle_count    = 0;

  // Traffic shaping knobs shared between the test tasks and the two channel processes.
  bit                        sender_gaps_on = 1'b1;
  bit                        sink_stalls_on = 1'b1;
  int                        sink_hold_req  = 0;
  bit                        sink_holding   = 1'b0;
  logic [brs_pkg::VER_W-1:0] file_ver       = brs_pkg::VER_W'(16);

  block_reception_scoreboard #(
    .MAX_BLOCKS(MAP_BLOCKS)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_block_index    (in_block_index),
    .in_total_blocks   (in_total_blocks),
    .in_file_version   (in_file_version),
    .in_creator_id     (in_creator_id),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_restarted     (out_restarted),
    .out_next_missing  (out_next_missing),
    .out_received_count(out_received_count),
    .out_complete      (out_complete)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------

  // A version is newer when its number is larger, or the numbers tie and the signed
  // creator id is larger.
  function automatic bit is_newer(logic [brs_pkg::VER_W-1:0] va,
                                  logic signed [brs_pkg::CRE_W-1:0] ca,
                                  logic [brs_pkg::VER_W-1:0] vb,
                                  logic signed [brs_pkg::CRE_W-1:0] cb);
    if (va == vb) begin
      return ca > cb;
    end
    return va > vb;
  endfunction

  // Lowest unmarked block below the tracked total; returns 0 when nothing is missing.
  function automatic bit lowest_missing(output logic [brs_pkg::IDX_W-1:0] pos);
    for (int i = 0; i < int'(trk_total); i++) begin
      if (!rx_map[i]) begin
        pos = brs_pkg::IDX_W'(i);
        return 1'b1;
      end
    end
    pos = '0;
    return 1'b0;
  endfunction

  // A rejected item leaves all state alone but still reports the tracked transfer, if any.
  function automatic reception_t rejection(logic [brs_pkg::ST_W-1:0] code);
    reception_t r;
    logic [brs_pkg::IDX_W-1:0] pos;
    r = '0;
    r.status = code;
    if (xfer_active) begin
      void'(lowest_missing(pos));
      r.first_gap      = pos;
      r.received_count = rx_count;
    end
    return r;
  endfunction

  function automatic reception_t predict_reception(logic [brs_pkg::IDX_W-1:0] idx,
                                                   logic [brs_pkg::TOT_W-1:0] tot,
                                                   logic [brs_pkg::VER_W-1:0] ver,
                                                   logic signed [brs_pkg::CRE_W-1:0] cre);
    reception_t r;
    logic restart;
    logic [brs_pkg::IDX_W-1:0] pos;
    r = '0;
    // Anything not newer than the committed version is stale.
    if (commit_ok && !is_newer(ver, cre, commit_ver, commit_cre)) begin
      return rejection(brs_pkg::ST_OLD);
    end
    // A newer version than the one being tracked (or no tracked one) starts over; the
    // exact tracked version continues; anything in between is stale.
    if (!xfer_active || is_newer(ver, cre, trk_ver, trk_cre)) begin
      restart = 1'b1;
    end else if (ver == trk_ver && cre == trk_cre) begin
      restart = 1'b0;
    end else begin
      return rejection(brs_pkg::ST_OLD);
    end
    if (restart) begin
      if (tot == 0 || tot > MAP_BLOCKS || idx >= tot) begin
        return rejection(brs_pkg::ST_RANGE);
      end
      rx_map      = '0;
      xfer_active = 1'b1;
      trk_ver     = ver;
      trk_cre     = cre;
      trk_total   = tot;
      rx_count    = '0;
    end else begin
      // On a continuing transfer the block count carried by the item is ignored.
      if (idx >= trk_total) begin
        return rejection(brs_pkg::ST_RANGE);
      end
      if (rx_map[idx]) begin
        return rejection(brs_pkg::ST_DUP);
      end
    end
    rx_map[idx] = 1'b1;
    rx_count    = rx_count + 1'b1;
    r.status         = brs_pkg::ST_ACCEPT;
    r.restarted      = restart;
    r.received_count = rx_count;
    if (lowest_missing(pos)) begin
      r.first_gap = pos;
    end else begin
      // Last missing block arrived: commit the version and close the transfer.
      commit_ok   = 1'b1;
      commit_ver  = trk_ver;
      commit_cre  = trk_cre;
      xfer_active = 1'b0;
      r.complete  = 1'b1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------------------

  // Offers one block after a random gap and holds it until the block takes it. Valid stays
  // high on return so that a following call with no gap streams items back to back.
  task automatic send_block(input logic [brs_pkg::IDX_W-1:0] idx,
                            input logic [brs_pkg::TOT_W-1:0] tot,
                            input logic [brs_pkg::VER_W-1:0] ver,
                            input logic signed [brs_pkg::CRE_W-1:0] cre);
    int gap;
    gap = sender_gaps_on ? $urandom_range(16, 0) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_block_index  <= idx;
    in_total_blocks <= tot;
    in_file_version <= ver;
    in_creator_id   <= cre;
    do @(posedge clk); while (in_stall);
    due_receptions.push_back(predict_reception(idx, tot, ver, cre));
    items_sent++;
  endtask

  // Drops valid before the test waits on something other than the input handshake.
  task automatic pause_sender();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------------------

  // The receiver stalls for a random number of cycles before each result. A test can ask
  // for one long hold through sink_hold_req; the count is kept here, not by the test.
  initial begin : result_sink
    int n;
    while (!rst_n) @(posedge clk);
    forever begin
      if (sink_hold_req > 0) begin
        n             = sink_hold_req;
        sink_hold_req = 0;
        sink_holding  = 1'b1;
      end else begin
        n = sink_stalls_on ? $urandom_range(16, 0) : 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      sink_holding = 1'b0;
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid && sink_hold_req == 0) @(posedge clk);
    end
  end

  // Every accepted result is compared with the oldest outstanding prediction.
  always @(posedge clk) begin : result_check
    reception_t got;
    reception_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_status, out_restarted, out_next_missing, out_received_count, out_complete};
      if (due_receptions.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("%0t: result with nothing outstanding:", $realtime,
                   " status=%0d restarted=%0d", got.status, got.restarted,
                   " next=%0d count=%0d complete=%0d", got.first_gap,
                   got.received_count, got.complete);
        end
      end else begin
        want = due_receptions.pop_front();
        if (got.status !== want.status || got.restarted !== want.restarted ||
            got.first_gap !== want.first_gap ||
            got.received_count !== want.received_count ||
            got.complete !== want.complete) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: mismatch (expected/actual):", $realtime,
                     " status %0d/%0d restarted %0d/%0d", want.status, got.status,
                     want.restarted, got.restarted,
                     " next %0d/%0d count %0d/%0d", want.first_gap, got.first_gap,
                     want.received_count, got.received_count,
                     " complete %0d/%0d", want.complete, got.complete);
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[block_reception_scoreboard] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // With nothing committed, the very first block is newer whatever its version. A one-block
  // file completes at once; repeating it is then stale and, with no transfer tracked,
  // reports zero for the position and the count.
  task automatic test_first_block();
    send_block(brs_pkg::IDX_W'(0), brs_pkg::TOT_W'(1), brs_pkg::VER_W'(0), 32'sh8000_0000);
    send_block(brs_pkg::IDX_W'(0), brs_pkg::TOT_W'(1), brs_pkg::VER_W'(0), 32'sh8000_0000);
  endtask

  // Block counts of zero and above the map size, and an index at the total, are refused on
  // a restart. The top index of a full-size file starts a transfer; afterwards the count
  // carried by continuing blocks is ignored, and a repeat is a duplicate.
  task automatic test_range_limits();
    send_block(brs_pkg::IDX_W'(0), brs_pkg::TOT_W'(0), brs_pkg::VER_W'(1), 32'sd0);
    send_block(brs_pkg::IDX_W'(0), brs_pkg::TOT_W'(2047), brs_pkg::VER_W'(1), 32'sd0);
    send_block(brs_pkg::IDX_W'(0), brs_pkg::TOT_W'(MAP_BLOCKS + 1), brs_pkg::VER_W'(1),
               32'sd0);
    send_block(brs_pkg::IDX_W'(4), brs_pkg::TOT_W'(4), brs_pkg::VER_W'(1), 32'sd0);
    send_block(brs_pkg::IDX_W'(1023), brs_pkg::TOT_W'(MAP_BLOCKS), brs_pkg::VER_W'(1),
               32'sd0);
    send_block(brs_pkg::IDX_W'(0), brs_pkg::TOT_W'(0), brs_pkg::VER_W'(1), 32'sd0);
    send_block(brs_pkg::IDX_W'(1023), brs_pkg::TOT_W'(7), brs_pkg::VER_W'(1), 32'sd0);
  endtask

  // Items newer than the commit but older than the tracked transfer are stale, as are
  // items that only tie the commit. The signed creator decides equal versions.
  task automatic test_stale_versions();
    send_block(brs_pkg::IDX_W'(5), brs_pkg::TOT_W'(8), brs_pkg::VER_W'(1), -32'sd1);
    send_block(brs_pkg::IDX_W'(5), brs_pkg::TOT_W'(8), brs_pkg::VER_W'(0), 32'sd5);
    send_block(brs_pkg::IDX_W'(5), brs_pkg::TOT_W'(8), brs_pkg::VER_W'(0), 32'sh8000_0000);
  endtask

  // A newer creator on the same version replaces the tracked full-size transfer. The new
  // file is completed out of order and its version is committed.
  task automatic test_replace_and_commit();
    send_block(brs_pkg::IDX_W'(2), brs_pkg::TOT_W'(3), brs_pkg::VER_W'(1), 32'sd1);
    send_block(brs_pkg::IDX_W'(0), brs_pkg::TOT_W'(MAP_BLOCKS), brs_pkg::VER_W'(1), 32'sd1);
    send_block(brs_pkg::IDX_W'(1), brs_pkg::TOT_W'(5), brs_pkg::VER_W'(1), 32'sd1);
    send_block(brs_pkg::IDX_W'(0), brs_pkg::TOT_W'(3), brs_pkg::VER_W'(1), 32'sd1);
  endtask

  // A refused restart by a newer version must leave the tracked transfer intact.
  task automatic test_refused_restart();
    send_block(brs_pkg::IDX_W'(1), brs_pkg::TOT_W'(2), brs_pkg::VER_W'(2), 32'sh7FFF_FFFF);
    send_block(brs_pkg::IDX_W'(0), brs_pkg::TOT_W'(0), brs_pkg::VER_W'(3), 32'sd0);
    send_block(brs_pkg::IDX_W'(3), brs_pkg::TOT_W'(2047), brs_pkg::VER_W'(3), 32'sd0);
    send_block(brs_pkg::IDX_W'(1), brs_pkg::TOT_W'(2), brs_pkg::VER_W'(2), 32'sh7FFF_FFFF);
    send_block(brs_pkg::IDX_W'(0), brs_pkg::TOT_W'(2), brs_pkg::VER_W'(2), 32'sh7FFF_FFFF);
  endtask

  // The receiver holds off for a long stretch while a new file streams in without gaps,
  // so the queue fills and the block has to stall its input.
  task automatic test_receiver_hold();
    logic signed [brs_pkg::CRE_W-1:0] cre;
    file_ver = file_ver + 1'b1;
    cre      = $urandom;
    pause_sender();
    sink_hold_req = 400;
    while (!sink_holding) @(posedge clk);
    sender_gaps_on = 1'b0;
    for (int i = 0; i < 8; i++) begin
      send_block(brs_pkg::IDX_W'(7 - i), brs_pkg::TOT_W'(8), file_ver, cre);
    end
    sender_gaps_on = 1'b1;
  endtask

  // Anything that is not a clean block of the current file: stale versions, indexes past
  // the end, refused restarts, a lower creator on the same version and random fields.
  task automatic send_noise(input logic [brs_pkg::VER_W-1:0] ver,
                            input logic signed [brs_pkg::CRE_W-1:0] cre,
                            input logic [brs_pkg::TOT_W-1:0] tot);
    case ($urandom_range(4, 0))
      0: send_block(brs_pkg::IDX_W'($urandom), brs_pkg::TOT_W'($urandom),
                    brs_pkg::VER_W'($urandom_range(int'(ver), 0)), $urandom);
      1: send_block(brs_pkg::IDX_W'($urandom_range(MAP_BLOCKS - 1,
                                    int'(tot) >= MAP_BLOCKS ? MAP_BLOCKS - 1 : int'(tot))),
                    tot, ver, cre);
      2: send_block(brs_pkg::IDX_W'($urandom),
                    $urandom_range(1, 0) ? brs_pkg::TOT_W'(0)
                                         : brs_pkg::TOT_W'($urandom_range(2047, 1025)),
                    ver + 1'b1, cre);
      3: send_block(brs_pkg::IDX_W'($urandom), brs_pkg::TOT_W'($urandom), ver, cre - 1);
      default: send_block(brs_pkg::IDX_W'($urandom), brs_pkg::TOT_W'($urandom), ver, cre);
    endcase
  endtask

  // Mostly well-formed files with random content: a newer version, a shuffled set of
  // blocks, some duplicates and continuing blocks with a junk count, noise in between,
  // and now and then an abandoned file. Large files only get a few blocks before the next
  // newer file replaces them.
  task automatic test_random_transfers(input int n_items);
    logic signed [brs_pkg::CRE_W-1:0] cre;
    logic [brs_pkg::TOT_W-1:0]        tot;
    logic [brs_pkg::TOT_W-1:0]        tot_field;
    int order[$];
    int first_item;
    int pick;
    int tmp;
    first_item = items_sent;
    while (items_sent - first_item < n_items) begin
      sender_gaps_on = ($urandom_range(3, 0) != 0);
      sink_stalls_on = ($urandom_range(3, 0) != 0);
      if ($urandom_range(7, 0) == 0) begin
        file_ver = file_ver + brs_pkg::VER_W'($urandom_range(1 << 20, 1));
      end else begin
        file_ver = file_ver + brs_pkg::VER_W'($urandom_range(2, 0));
      end
      cre = $urandom;
      tot = ($urandom_range(15, 0) == 0) ? brs_pkg::TOT_W'($urandom_range(MAP_BLOCKS, 13))
                                         : brs_pkg::TOT_W'($urandom_range(12, 1));
      order.delete();
      if (tot <= 12) begin
        for (int i = 0; i < int'(tot); i++) begin
          order.push_back(i);
        end
        for (int i = order.size() - 1; i > 0; i--) begin
          pick        = $urandom_range(i, 0);
          tmp         = order[i];
          order[i]    = order[pick];
          order[pick] = tmp;
        end
      end else begin
        for (int i = $urandom_range(8, 3); i > 0; i--) begin
          order.push_back($urandom_range(int'(tot) - 1, 0));
        end
        order.push_back(int'(tot) - 1);
      end
      foreach (order[i]) begin
        if ($urandom_range(19, 0) == 0) begin
          break;
        end
        tot_field = ($urandom_range(7, 0) == 0) ? brs_pkg::TOT_W'($urandom) : tot;
        send_block(brs_pkg::IDX_W'(order[i]), tot_field, file_ver, cre);
        if (i > 0 && $urandom_range(7, 0) == 0) begin
          send_block(brs_pkg::IDX_W'(order[$urandom_range(i, 0)]), tot, file_ver, cre);
        end
        if ($urandom_range(5, 0) == 0) begin
          send_noise(file_ver, cre, tot);
        end
      end
    end
    sender_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  // The highest version with the highest creator is committed last; nothing can be newer
  // afterwards, so every further block is stale.
  task automatic test_version_ceiling();
    send_block(brs_pkg::IDX_W'(1023), brs_pkg::TOT_W'(MAP_BLOCKS), {brs_pkg::VER_W{1'b1}},
               32'sh7FFF_FFFE);
    send_block(brs_pkg::IDX_W'(0), brs_pkg::TOT_W'(1), {brs_pkg::VER_W{1'b1}},
               32'sh7FFF_FFFF);
    for (int i = 0; i < 4; i++) begin
      send_block(brs_pkg::IDX_W'($urandom), brs_pkg::TOT_W'($urandom),
                 {brs_pkg::VER_W{1'b1}}, $urandom);
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------------------
  initial begin
    rx_map      = '0;
    xfer_active = 1'b0;
    trk_ver     = '0;
    trk_cre     = '0;
    trk_total   = '0;
    rx_count    = '0;
    commit_ok   = 1'b0;
    commit_ver  = '0;
    commit_cre  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_first_block();
    test_range_limits();
    test_stale_versions();
    test_replace_and_commit();
    test_refused_restart();
    test_receiver_hold();
    test_random_transfers(600);
    test_version_ceiling();
    pause_sender();

    // Drain, then keep the clock running so that any stray result still shows.
    while (due_receptions.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[block_reception_scoreboard] OK");
    end else begin
      $display("[block_reception_scoreboard] ERROR");
    end
    $finish;
  end

endmodule
